/* rtl/qmfap_pkg.sv */
package qmfap_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WIDE_W = 36;
  localparam int COEF_W = 16;
  localparam int COEF_FRAC = 16;
  localparam int COEF_PER_BRANCH = 3;
  localparam int NUM_REGS = 6;
  localparam int CFG_IDX_W = 3;
  localparam int SECTIONS_DEFAULT = 3;
  localparam int FRAC_BITS_DEFAULT = 16;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_A_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A_THIRD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_FIRST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B_SECOND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_B_THIRD = 3'd5;

  typedef logic [COEF_PER_BRANCH-1:0][COEF_W-1:0] coef_set_t;

  // element 0 is the first section
  localparam coef_set_t COEF_A_RESET = {16'd63010, 16'd49062, 16'd21333};
  localparam coef_set_t COEF_B_RESET = {16'd57261, 16'd36982, 16'd6418};

  localparam logic signed [63:0] WIDE_MAX = (64'sd1 <<< (WIDE_W - 1)) - 64'sd1;
  localparam logic signed [63:0] WIDE_MIN = -(64'sd1 <<< (WIDE_W - 1));

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] even_sample;
    logic signed [SAMPLE_W-1:0] odd_sample;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] lower_band;
    logic signed [SAMPLE_W-1:0] upper_band;
  } out_t;

  // clamp to the internal signed range
  function automatic logic signed [WIDE_W-1:0] sat_wide(input logic signed [63:0] v);
    logic signed [WIDE_W-1:0] r;
    if (v > WIDE_MAX) begin
      r = WIDE_MAX[WIDE_W-1:0];
    end else if (v < WIDE_MIN) begin
      r = WIDE_MIN[WIDE_W-1:0];
    end else begin
      r = v[WIDE_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/qmfap_lane.sv */
module qmfap_lane #(
  parameter int SECTIONS = qmfap_pkg::SECTIONS_DEFAULT,
  parameter int FRAC_BITS = qmfap_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [qmfap_pkg::SAMPLE_W-1:0]  sample,
  input  qmfap_pkg::coef_set_t                   coefs,
  output logic                                   done,
  output logic signed [qmfap_pkg::WIDE_W-1:0]    y
);

  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int PROD_W = qmfap_pkg::COEF_W + 1 + qmfap_pkg::WIDE_W;
  localparam logic signed [PROD_W-1:0] RND =
    PROD_W'(64'sd1 <<< (qmfap_pkg::COEF_FRAC - 1));

  localparam logic [1:0] PH_MUL_X = 2'd0;
  localparam logic [1:0] PH_ADD_Y = 2'd1;
  localparam logic [1:0] PH_MUL_Y = 2'd2;
  localparam logic [1:0] PH_ADD_D = 2'd3;

  logic                                  running;
  logic [1:0]                            phase;
  logic [SEC_W-1:0]                      sec;
  logic signed [qmfap_pkg::WIDE_W-1:0]   x;
  logic signed [qmfap_pkg::WIDE_W-1:0]   prod;
  logic signed [qmfap_pkg::WIDE_W-1:0]   delay [SECTIONS];

  logic [qmfap_pkg::COEF_W-1:0]          c;
  logic signed [qmfap_pkg::WIDE_W-1:0]   mul_in;
  logic signed [PROD_W-1:0]              mul_full;
  logic signed [PROD_W-1:0]              mul_rnd;
  logic signed [qmfap_pkg::WIDE_W-1:0]   mul_out;
  logic                                  last_sec;

  // sections past the configured ones have a zero coefficient (pure delay)
  always_comb begin
    c = '0;
    for (int i = 0; i < qmfap_pkg::COEF_PER_BRANCH; i++) begin
      if (int'(sec) == i) begin
        c = coefs[i];
      end
    end
  end

  // one shared multiplier, fed with x or y depending on the phase
  assign mul_in = (phase == PH_MUL_X) ? x : y;
  assign mul_full = $signed({1'b0, c}) * mul_in;
  assign mul_rnd = (mul_full + RND) >>> qmfap_pkg::COEF_FRAC;
  assign mul_out = qmfap_pkg::sat_wide(64'(mul_rnd));
  assign last_sec = (sec == SEC_W'(SECTIONS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      phase <= PH_MUL_X;
      sec <= '0;
      done <= 1'b0;
      for (int i = 0; i < SECTIONS; i++) begin
        delay[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        phase <= PH_MUL_X;
        sec <= '0;
        x <= qmfap_pkg::sat_wide(64'(sample) <<< FRAC_BITS);
      end else if (running) begin
        unique case (phase)
          PH_MUL_X: begin
            prod <= mul_out;
            phase <= PH_ADD_Y;
          end
          PH_ADD_Y: begin
            y <= qmfap_pkg::sat_wide(64'(prod) + 64'(delay[sec]));
            phase <= PH_MUL_Y;
          end
          PH_MUL_Y: begin
            prod <= mul_out;
            phase <= PH_ADD_D;
          end
          PH_ADD_D: begin
            delay[sec] <= qmfap_pkg::sat_wide(64'(x) - 64'(prod));
            x <= y;
            phase <= PH_MUL_X;
            if (last_sec) begin
              running <= 1'b0;
              done <= 1'b1;
            end else begin
              sec <= sec + SEC_W'(1);
            end
          end
          default: begin
            phase <= PH_MUL_X;
          end
        endcase
      end
    end
  end

endmodule

/* rtl/qmfap_merge.sv */
module qmfap_merge #(
  parameter int FRAC_BITS = qmfap_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic signed [qmfap_pkg::WIDE_W-1:0]  ya,
  input  logic signed [qmfap_pkg::WIDE_W-1:0]  yb,
  output logic                                 free,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output qmfap_pkg::out_t                      out_data
);

  localparam int SUM_W = qmfap_pkg::WIDE_W + 2;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(32768);

  logic signed [SUM_W-1:0] sum_t;
  logic signed [SUM_W-1:0] dif_t;
  logic signed [SUM_W-1:0] sum_s;
  logic signed [SUM_W-1:0] dif_s;
  qmfap_pkg::out_t         res;

  function automatic logic signed [qmfap_pkg::SAMPLE_W-1:0] clamp16(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [qmfap_pkg::SAMPLE_W-1:0] r;
    if (v > OUT_MAX) begin
      r = OUT_MAX[qmfap_pkg::SAMPLE_W-1:0];
    end else if (v < OUT_MIN) begin
      r = OUT_MIN[qmfap_pkg::SAMPLE_W-1:0];
    end else begin
      r = v[qmfap_pkg::SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // round half up, then halve back to sample scale
  assign sum_t = SUM_W'(ya) + SUM_W'(yb) + HALF;
  assign dif_t = SUM_W'(ya) - SUM_W'(yb) + HALF;
  assign sum_s = sum_t >>> (FRAC_BITS + 1);
  assign dif_s = dif_t >>> (FRAC_BITS + 1);
  assign res.lower_band = clamp16(sum_s);
  assign res.upper_band = clamp16(dif_s);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

endmodule

/* rtl/qmf_allpass_band_split_top.sv */
// Two-band analysis split built from two polyphase all-pass branches. Each request
// carries an even and an odd 16-bit sample; the even sample runs through branch A
// and the odd sample through branch B, each a cascade of SECTIONS first-order
// all-pass sections in transposed form with 36-bit saturating arithmetic and
// FRAC_BITS fraction bits. The outputs are lower_band = (A+B)/2 and
// upper_band = (A-B)/2, rounded half up and saturated to int16. The two branches
// run side by side in lanes of their own, each with one shared 17x36 multiplier
// that is used twice per section. A request holds the lanes until its result is
// loaded into the result register; no new request is taken while one is in the
// lanes. The result register frees the lanes, so a waiting result does not block
// the next request unless the following one finishes before the first is taken.
// Coefficients are unsigned Q0.16; the user must write them through the config
// port only while the block is idle, as the block itself does not enforce this;
// sections beyond the third use a zero coefficient and act as a one-sample delay.
module qmf_allpass_band_split_top #(
  parameter int SECTIONS = qmfap_pkg::SECTIONS_DEFAULT,
  parameter int FRAC_BITS = qmfap_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // sample pair request
  input  logic                               in_valid,
  output logic                               in_ready,
  input  qmfap_pkg::in_t                     in_data,
  // band result
  output logic                               out_valid,
  input  logic                               out_ready,
  output qmfap_pkg::out_t                    out_data,
  // coefficient writes
  input  logic                               cfg_write,
  input  logic [qmfap_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qmfap_pkg::COEF_W-1:0]       cfg_data
);

  // control states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]                          state;
  logic [1:0]                          state_next;
  qmfap_pkg::coef_set_t                coef_a;
  qmfap_pkg::coef_set_t                coef_b;
  logic                                accept;
  logic                                done_a;
  logic                                done_b;
  logic signed [qmfap_pkg::WIDE_W-1:0] ya;
  logic signed [qmfap_pkg::WIDE_W-1:0] yb;
  logic                                out_free;
  logic                                load;

  // coefficient registers, writes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= qmfap_pkg::COEF_A_RESET;
      coef_b <= qmfap_pkg::COEF_B_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        qmfap_pkg::REG_A_FIRST:  coef_a[0] <= cfg_data;
        qmfap_pkg::REG_A_SECOND: coef_a[1] <= cfg_data;
        qmfap_pkg::REG_A_THIRD:  coef_a[2] <= cfg_data;
        qmfap_pkg::REG_B_FIRST:  coef_b[0] <= cfg_data;
        qmfap_pkg::REG_B_SECOND: coef_b[1] <= cfg_data;
        qmfap_pkg::REG_B_THIRD:  coef_b[2] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign accept = in_valid && in_ready;

  // both lanes share one schedule, so lane a's done stands for both
  always_comb begin
    state_next = state;
    load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (done_a) begin
          if (out_free) begin
            load = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // branch a: even samples
  qmfap_lane #(
    .SECTIONS(SECTIONS),
    .FRAC_BITS(FRAC_BITS)
  ) u_lane_a (
    .clk(clk),
    .rst(rst),
    .start(accept),
    .sample(in_data.even_sample),
    .coefs(coef_a),
    .done(done_a),
    .y(ya)
  );

  // branch b: odd samples
  qmfap_lane #(
    .SECTIONS(SECTIONS),
    .FRAC_BITS(FRAC_BITS)
  ) u_lane_b (
    .clk(clk),
    .rst(rst),
    .start(accept),
    .sample(in_data.odd_sample),
    .coefs(coef_b),
    .done(done_b),
    .y(yb)
  );

  // half sum / half difference and the result register
  qmfap_merge #(
    .FRAC_BITS(FRAC_BITS)
  ) u_merge (
    .clk(clk),
    .rst(rst),
    .load(load),
    .ya(ya),
    .yb(yb),
    .free(out_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

`ifndef NO_ASSERTIONS
  // the two lanes must finish together
  assert property (@(posedge clk) disable iff (rst) done_a == done_b)
    else $error("branch lanes finished out of step");

  // a result only appears after the lanes have finished
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_RUN || state == ST_HOLD))
    else $error("result appeared without a finished request");

  // holding means the result register is occupied
  assert property (@(posedge clk) disable iff (rst) state == ST_HOLD |-> out_valid)
    else $error("holding with a free result register");

  // no second request while one is in the lanes
  assert property (@(posedge clk) disable iff (rst) accept |=> !in_ready)
    else $error("request taken while lanes busy");
`endif

endmodule

/* dv/tb_qmf_allpass_band_split_top.sv */
`timescale 1ns / 1ps

module tb_qmf_allpass_band_split_top;
  import qmfap_pkg::*;

  // block configuration under test, passed to the instance below
  localparam int N_SECT = SECTIONS_DEFAULT;
  localparam int FRAC = FRAC_BITS_DEFAULT;

  // run control
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 4 * N_SECT + 20;  // well past one request's latency
  localparam int PHASE_ITEMS = 135;
  localparam int PATTERN_LEN = 48;

  // indexes past the register list, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_PAST_END = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_SLOT = 3'd7;

  localparam int BRANCH_A = 0;
  localparam int BRANCH_B = 1;

  localparam logic signed [SAMPLE_W-1:0] FULL_POS = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 16'sh8000;
  localparam logic [COEF_W-1:0] COEF_NONE = 16'h0000;
  localparam logic [COEF_W-1:0] COEF_FULL = 16'hffff;
  localparam coef_set_t SET_NONE = {COEF_PER_BRANCH{COEF_NONE}};
  localparam coef_set_t SET_FULL = {COEF_PER_BRANCH{COEF_FULL}};
  localparam longint IMPULSE = longint'(FULL_POS) <<< FRAC;

  // shapes of random request runs
  typedef enum int {
    BURST_NOISE,
    BURST_ALTERNATE,
    BURST_STEP,
    BURST_QUIET,
    BURST_WORST
  } burst_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  // shadow of the coefficient registers and the transposed section delays
  logic [COEF_W-1:0] coef_q [NUM_REGS];
  longint dly [2][N_SECT];

  // band results still owed by the block, oldest first
  out_t expected_bands [$];

  int mismatch_count = 0;
  int idle_pct = 0;   // chance per cycle that the sender holds off
  int stall_pct = 0;  // chance per cycle that the receiver is not ready
  int cycle_count = 0;

  qmf_allpass_band_split_top #(
    .SECTIONS(N_SECT),
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // band split predictor
  // ---------------------------------------------------------------------------

  // clamp to the 36-bit internal range
  function automatic longint clamp_wide(input longint v);
    if (v > WIDE_MAX) begin
      return WIDE_MAX;
    end else if (v < WIDE_MIN) begin
      return WIDE_MIN;
    end
    return v;
  endfunction

  // Q0.16 coefficient times internal value, round half up (floor shift)
  function automatic longint scaled_mul(input logic [COEF_W-1:0] c, input longint v);
    longint cl;
    longint p;
    cl = longint'(c);
    p = v * cl + (longint'(1) <<< (COEF_FRAC - 1));
    return clamp_wide(p >>> COEF_FRAC);
  endfunction

  // one sample through a cascade of transposed all-pass sections
  function automatic longint allpass_chain(input int br, input longint x);
    longint y;
    logic [COEF_W-1:0] c;
    for (int k = 0; k < N_SECT; k++) begin
      // sections past the third have no register: plain one-sample delay
      c = (k < COEF_PER_BRANCH) ? coef_q[br * COEF_PER_BRANCH + k] : COEF_NONE;
      y = clamp_wide(scaled_mul(c, x) + dly[br][k]);
      dly[br][k] = clamp_wide(x - scaled_mul(c, y));
      x = y;
    end
    return x;
  endfunction

  // drop the fraction bits plus the halving, round half up, saturate to int16
  function automatic logic signed [SAMPLE_W-1:0] to_band(input longint v);
    longint r;
    r = (v + (longint'(1) <<< FRAC)) >>> (FRAC + 1);
    if (r > FULL_POS) begin
      r = FULL_POS;
    end else if (r < FULL_NEG) begin
      r = FULL_NEG;
    end
    return r[SAMPLE_W-1:0];
  endfunction

  // even sample into branch A, odd into branch B, then half sum and half difference
  function automatic out_t split_pair(input in_t item);
    longint xa;
    longint xb;
    longint ya;
    longint yb;
    out_t res;
    xa = longint'(item.even_sample);
    xb = longint'(item.odd_sample);
    ya = allpass_chain(BRANCH_A, clamp_wide(xa <<< FRAC));
    yb = allpass_chain(BRANCH_B, clamp_wide(xb <<< FRAC));
    res.lower_band = to_band(ya + yb);
    res.upper_band = to_band(ya - yb);
    return res;
  endfunction

  // sign pattern that lines full-scale samples up against the branch's
  // impulse response, pushing its output and delays as far out as it goes;
  // works on a scratch copy so the tracked delays stay untouched
  function automatic logic [PATTERN_LEN-1:0] worst_signs(input int br);
    longint saved [2][N_SECT];
    longint y;
    logic [PATTERN_LEN-1:0] signs;
    saved = dly;
    dly = '{default: 0};
    for (int n = 0; n < PATTERN_LEN; n++) begin
      y = allpass_chain(br, (n == 0) ? IMPULSE : longint'(0));
      signs[PATTERN_LEN-1-n] = (y < 0);
    end
    dly = saved;
    return signs;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer one sample pair, hold it until taken, then log its expected bands;
  // valid is left high so back-to-back requests need no second assignment
  task automatic send_pair(input logic signed [SAMPLE_W-1:0] ev,
                           input logic signed [SAMPLE_W-1:0] od);
    in_t item;
    item.even_sample = ev;
    item.odd_sample = od;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_bands = {expected_bands, split_pair(item)};
  endtask

  // stop offering requests, wait for every owed result, then let the lanes drain
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_bands.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write; the caller drops cfg_write after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx < NUM_REGS) coef_q[idx] = val;
  endtask

  task automatic load_coefs(input coef_set_t a_set, input coef_set_t b_set);
    write_reg(REG_A_FIRST, a_set[0]);
    write_reg(REG_A_SECOND, a_set[1]);
    write_reg(REG_A_THIRD, a_set[2]);
    write_reg(REG_B_FIRST, b_set[0]);
    write_reg(REG_B_SECOND, b_set[1]);
    write_reg(REG_B_THIRD, b_set[2]);
    cfg_write <= 1'b0;
  endtask

  // random coefficients, with the extremes zero and full scale drawn half the time
  function automatic coef_set_t rand_set();
    coef_set_t s;
    for (int k = 0; k < COEF_PER_BRANCH; k++) begin
      case ($urandom_range(3))
        0: s[k] = COEF_NONE;
        1: s[k] = COEF_FULL;
        default: s[k] = COEF_W'($urandom_range(65535));
      endcase
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %0s", cycle_count, msg);
    mismatch_count++;
  endtask

  // receiver backpressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_bands.size() == 0) begin
        report_mismatch($sformatf("result lower %0d upper %0d with nothing owed",
                                  out_data.lower_band, out_data.upper_band));
      end else begin
        want = expected_bands.pop_front();
        if (out_data.lower_band !== want.lower_band) begin
          report_mismatch($sformatf("lower_band got %0d expected %0d",
                                    out_data.lower_band, want.lower_band));
        end
        if (out_data.upper_band !== want.upper_band) begin
          report_mismatch($sformatf("upper_band got %0d expected %0d",
                                    out_data.upper_band, want.upper_band));
        end
      end
    end
  end

  // hard stop if the handshakes ever hang
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset coefficients: silence, full-scale pairs of both signs, unit steps
  task automatic test_reset_coefs();
    send_pair(16'sd0, 16'sd0);
    send_pair(FULL_POS, FULL_POS);
    send_pair(FULL_NEG, FULL_NEG);
    send_pair(FULL_POS, FULL_NEG);
    send_pair(FULL_NEG, FULL_POS);
    send_pair(16'sd0, 16'sd0);
    send_pair(16'sd1, -16'sd1);
    send_pair(-16'sd1, 16'sd1);
    settle();
  endtask

  // writes past the register list must leave every coefficient alone
  task automatic test_ignored_index();
    write_reg(REG_PAST_END, COEF_FULL);
    write_reg(REG_TOP_SLOT, COEF_W'($urandom_range(65535)));
    cfg_write <= 1'b0;
    send_pair(FULL_POS, FULL_NEG);
    send_pair(16'sd12345, -16'sd321);
    settle();
  endtask

  // zero coefficients turn every section into a one-sample delay
  task automatic test_zero_coefs();
    load_coefs(SET_NONE, SET_NONE);
    send_pair(FULL_POS, FULL_NEG);
    send_pair(FULL_NEG, FULL_POS);
    send_pair(16'sd12345, -16'sd4321);
    send_pair(16'sd0, 16'sd0);
    settle();
  endtask

  // coefficients at full scale: poles near the unit circle, alternating
  // full-scale input then a broken alternation to swing the state hard
  task automatic test_full_coefs();
    load_coefs(SET_FULL, SET_FULL);
    for (int n = 0; n < 5; n++) begin
      send_pair((n % 2) ? FULL_NEG : FULL_POS, (n % 2) ? FULL_POS : FULL_NEG);
    end
    send_pair(FULL_POS, FULL_NEG);
    send_pair(FULL_POS, FULL_NEG);
    send_pair(FULL_NEG, FULL_NEG);
    settle();
  endtask

  // random runs of well-formed signal shapes under one coefficient setting
  // and one idling mix
  task automatic test_random_phase(input int idle, input int stall,
                                   input coef_set_t a_set, input coef_set_t b_set);
    int done;
    int len;
    burst_e kind;
    logic signed [SAMPLE_W-1:0] ev;
    logic signed [SAMPLE_W-1:0] od;
    logic [PATTERN_LEN-1:0] signs_a;
    logic [PATTERN_LEN-1:0] signs_b;
    load_coefs(a_set, b_set);
    idle_pct = idle;
    stall_pct = stall;
    done = 0;
    while (done < PHASE_ITEMS) begin
      kind = burst_e'($urandom_range(BURST_WORST));
      len = $urandom_range(32, 4);
      case (kind)
        BURST_NOISE: begin
          for (int n = 0; n < len; n++) begin
            send_pair(SAMPLE_W'($urandom_range(65535)), SAMPLE_W'($urandom_range(65535)));
          end
        end
        BURST_ALTERNATE: begin
          // near-Nyquist drive, random full-scale-ish amplitude
          ev = SAMPLE_W'($urandom_range(32767, 16384));
          od = $urandom_range(1) ? ev : -ev;
          for (int n = 0; n < len; n++) begin
            send_pair((n % 2) ? -ev : ev, (n % 2) ? -od : od);
          end
        end
        BURST_STEP: begin
          ev = $urandom_range(1) ? FULL_POS : FULL_NEG;
          od = $urandom_range(1) ? FULL_POS : FULL_NEG;
          for (int n = 0; n < len; n++) begin
            send_pair(ev, od);
          end
        end
        BURST_QUIET: begin
          // small values exercise the rounding near zero
          for (int n = 0; n < len; n++) begin
            send_pair(SAMPLE_W'(int'($urandom_range(512)) - 256),
                      SAMPLE_W'(int'($urandom_range(512)) - 256));
          end
        end
        default: begin
          signs_a = worst_signs(BRANCH_A);
          signs_b = worst_signs(BRANCH_B);
          len = PATTERN_LEN;
          for (int n = 0; n < len; n++) begin
            send_pair(signs_a[n] ? FULL_NEG : FULL_POS, signs_b[n] ? FULL_NEG : FULL_POS);
          end
        end
      endcase
      done += len;
    end
    settle();
  endtask

  initial begin
    for (int k = 0; k < COEF_PER_BRANCH; k++) begin
      coef_q[BRANCH_A * COEF_PER_BRANCH + k] = COEF_A_RESET[k];
      coef_q[BRANCH_B * COEF_PER_BRANCH + k] = COEF_B_RESET[k];
    end
    dly = '{default: 0};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short directed part, no idling
    test_reset_coefs();
    test_ignored_index();
    test_zero_coefs();
    test_full_coefs();

    // random part: no idling, sender gaps, receiver stalls, then both
    test_random_phase(0, 0, rand_set(), rand_set());
    test_random_phase(47, 0, COEF_A_RESET, COEF_B_RESET);
    test_random_phase(0, 47, rand_set(), rand_set());
    test_random_phase(14, 14, rand_set(), rand_set());

    if (mismatch_count == 0 && expected_bands.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/qmfap_pkg.sv
rtl/qmfap_lane.sv
rtl/qmfap_merge.sv
rtl/qmf_allpass_band_split_top.sv
dv/tb_qmf_allpass_band_split_top.sv
